FILE: sv/weighted_neighbour_average_3x3_unit_assert.svh
// Assertion macros for the weighted neighbour average unit.
// Used by the port checker; expects clk and arst_n in scope.
`ifndef WEIGHTED_NEIGHBOUR_AVERAGE_3X3_UNIT_ASSERT_SVH
`define WEIGHTED_NEIGHBOUR_AVERAGE_3X3_UNIT_ASSERT_SVH

// Checked only outside reset.
`define WNA_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define WNA_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: sv/wna_pkg.sv
// Shared constants and types for the weighted neighbour average unit.
// No dependencies; imported by wna_calc and the top level.
package wna_pkg;

	localparam int MAX_SIZE  = 32;
	localparam int COL_W     = $clog2(MAX_SIZE);
	localparam int PIX_W     = 16;
	localparam int AVG_W     = 22;
	localparam int CFG_W     = 6;
	localparam int CFG_IDX_W = 1;

	// register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_COLS = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_ROWS = 1'b1;

	localparam logic [CFG_W-1:0] SIZE_RESET = 6'd20;
	localparam logic [CFG_W-1:0] SIZE_MIN   = 6'd2;
	localparam logic [CFG_W-1:0] SIZE_MAX   = CFG_W'(MAX_SIZE);

	// floor(x/5) = (x * DIV5_MUL) >> DIV5_SHIFT, exact for x < 2**25/3
	localparam int DIV5_X_W = 23;
	localparam int DIV5_SHIFT = 25;
	localparam logic [DIV5_X_W-1:0] DIV5_MUL = 23'd6710887;

	typedef struct packed {
		logic signed [PIX_W-1:0] top;
		logic signed [PIX_W-1:0] mid;
		logic signed [PIX_W-1:0] bot;
	} column_t;

	typedef struct packed {
		logic [COL_W-1:0] row;
		logic [COL_W-1:0] col;
		logic             run_last;
		logic             frame_last;
	} meta_t;

	// one column feed entering the window
	typedef struct packed {
		logic  valid;
		logic  first;
		logic  emit;
		meta_t meta;
	} feed_t;

endpackage

FILE: sv/wna_calc.sv
// Window registers and weighted-sum / divide-by-5 pipeline.
// Depends on wna_pkg; stalls on adv from the top level.
module wna_calc (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                adv,
	input  wna_pkg::feed_t                      cmd_s1,
	input  wna_pkg::column_t                    col_new,
	output logic                                res_valid,
	output logic signed [wna_pkg::AVG_W-1:0]    res_avg,
	output wna_pkg::meta_t                      res_meta
);
	import wna_pkg::*;

	localparam int SUM_W  = PIX_W + 2;
	localparam int T_W    = SUM_W + 3;
	localparam int MAG_W  = T_W - 1;
	localparam int PROD_W = 2 * DIV5_X_W;
	localparam int Q_W    = PROD_W - DIV5_SHIFT;

	column_t col_a_q, col_b_q;

	logic signed [SUM_W-1:0] d_sum, o_sum, d_s2, o_s2;
	logic                    v_s2, v_s3, v_s4;
	meta_t                   meta_s2, meta_s3, meta_s4;
	logic signed [T_W-1:0]   t_val, t_abs;
	logic [DIV5_X_W-1:0]     x_val, x_s3;
	logic                    neg_s3, neg_s4;
	logic [PROD_W-1:0]       prod;
	logic [Q_W-1:0]          q_s4;

	// window is col_a (left), col_b (center), col_new (right)
	assign d_sum = SUM_W'($signed(col_a_q.top)) + SUM_W'($signed(col_a_q.bot))
		+ SUM_W'($signed(col_new.top)) + SUM_W'($signed(col_new.bot));
	assign o_sum = SUM_W'($signed(col_b_q.top)) + SUM_W'($signed(col_b_q.bot))
		+ SUM_W'($signed(col_a_q.mid)) + SUM_W'($signed(col_new.mid));

	assign t_val = (T_W'(d_s2) <<< 1) + (T_W'(o_s2) <<< 1) + T_W'(o_s2);
	assign t_abs = t_val[T_W-1] ? -t_val : t_val;
	assign x_val = {t_abs[MAG_W-1:0], 3'b000} + DIV5_X_W'(2);

	assign prod = PROD_W'(x_s3) * PROD_W'(DIV5_MUL);

	always_ff @(posedge clk) begin
		if (adv && cmd_s1.valid) begin
			col_a_q <= cmd_s1.first ? '0 : col_b_q;
			col_b_q <= col_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2      <= 1'b0;
			v_s3      <= 1'b0;
			v_s4      <= 1'b0;
			res_valid <= 1'b0;
		end else if (adv) begin
			v_s2      <= cmd_s1.valid && cmd_s1.emit;
			v_s3      <= v_s2;
			v_s4      <= v_s3;
			res_valid <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			d_s2     <= d_sum;
			o_s2     <= o_sum;
			meta_s2  <= cmd_s1.meta;
			x_s3     <= x_val;
			neg_s3   <= t_val[T_W-1];
			meta_s3  <= meta_s2;
			q_s4     <= prod[PROD_W-1:DIV5_SHIFT];
			neg_s4   <= neg_s3;
			meta_s4  <= meta_s3;
			res_avg  <= neg_s4 ? -$signed(AVG_W'(q_s4)) : $signed(AVG_W'(q_s4));
			res_meta <= meta_s4;
		end
	end

endmodule

FILE: sv/weighted_neighbour_average_3x3_unit.sv
// Weighted neighbour average over a zero-padded 3x3 window, streamed in raster order.
// A fed column's result passes cmd_s1, stages s2, s3 and s4, and then the output register.
// Throughput: 1 pixel per cycle while the result stream is not stalled; the end of each row
// after row 0 holds input for the row tail, the frame's last pixel for the row tail, last-row flush and flush tail.
// Rate is set by the single row memory and the one-column-per-cycle window; a stalled result
// stream holds everything. Reset (arst_n low): control, counters, sizes (20x20) clear.
module weighted_neighbour_average_3x3_unit (
	input  logic                               clk,
	input  logic                               arst_n,
	// input stream
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	input  logic [15:0]                        s_axis_tdata,  // [15:0] pixel
	// result stream
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	output logic [31:0]                        m_axis_tdata,  // [21:0] average, [26:22] out_row,
	                                                          // [31:27] out_col
	output logic                               m_axis_tlast,  // run_last
	output logic                               m_axis_tuser,  // frame_last
	// configuration
	input  logic                               cfg_we,
	input  logic [wna_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [wna_pkg::CFG_W-1:0]          cfg_data
);
	import wna_pkg::*;

	localparam int BANK_W    = 2;
	localparam int MEM_DEPTH = 3 * (2 ** COL_W);
	localparam int MEM_AW    = BANK_W + COL_W;

	// Column sequencer: stream pixels, then the zero column at a row end,
	// then the last-row flush and its zero column at the frame end.
	typedef enum logic [3:0] {
		ST_STREAM     = 4'b0001,
		ST_ROW_TAIL   = 4'b0010,
		ST_FLUSH      = 4'b0100,
		ST_FLUSH_TAIL = 4'b1000
	} seq_state_t;

	// where the three values of a fed column come from
	typedef struct packed {
		logic use_rd;     // top/mid from memory, else zero
		logic top_en;     // top row exists
		logic bot_pixel;  // bottom is the incoming pixel, else zero
	} col_src_t;

	seq_state_t state_q;
	logic [CFG_W-1:0]  cols_q, rows_q;
	logic [CFG_W-1:0]  ncol, nrow, ncol_m1, nrow_m1;
	logic [COL_W-1:0]  last_col, last_row;
	logic [COL_W-1:0]  row_q, col_q, flush_col_q, tail_row_q;
	logic              frame_end_q;
	logic [BANK_W-1:0] low_bank_q, mid_bank, up_bank;
	logic              adv, accept, row_end, frame_end;

	logic [PIX_W-1:0]  row_mem [0:MEM_DEPTH-1];
	logic [MEM_AW-1:0] addr_a, addr_b, addr_w;
	logic [PIX_W-1:0]  rd_a_s1, rd_b_s1, pixel_s1;

	feed_t    feed, cmd_s1;
	col_src_t src, src_s1;
	column_t  col_new;

	logic                    res_valid;
	logic signed [AVG_W-1:0] res_avg;
	meta_t                   res_meta;

	// Clamp the sizes to 2..MAX_SIZE.
	always_comb begin
		ncol = (cols_q < SIZE_MIN) ? SIZE_MIN : ((cols_q > SIZE_MAX) ? SIZE_MAX : cols_q);
		nrow = (rows_q < SIZE_MIN) ? SIZE_MIN : ((rows_q > SIZE_MAX) ? SIZE_MAX : rows_q);
		ncol_m1 = ncol - CFG_W'(1);
		nrow_m1 = nrow - CFG_W'(1);
	end
	assign last_col = ncol_m1[COL_W-1:0];
	assign last_row = nrow_m1[COL_W-1:0];

	// Three row banks rotate: lower is being written, middle and upper lie above it.
	always_comb begin
		unique case (low_bank_q)
			2'd0:    begin mid_bank = 2'd2; up_bank = 2'd1; end
			2'd1:    begin mid_bank = 2'd0; up_bank = 2'd2; end
			2'd2:    begin mid_bank = 2'd1; up_bank = 2'd0; end
			default: begin mid_bank = 2'd0; up_bank = 2'd0; end
		endcase
	end

	// Advance the whole pipeline whenever the output register is free or being taken.
	assign adv           = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = adv && (state_q == ST_STREAM);
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign row_end       = (col_q == last_col);
	assign frame_end     = row_end && (row_q == last_row);

	// Build the column feed for this cycle.
	always_comb begin
		feed   = '0;
		src    = '0;
		addr_a = {up_bank, col_q};
		addr_b = {mid_bank, col_q};
		unique case (state_q)
			ST_STREAM: begin
				// pixel (i,j) completes the window of (i-1,j-1)
				feed.valid         = accept;
				feed.first         = (col_q == '0);
				feed.emit          = (row_q != '0) && (col_q != '0);
				feed.meta.row      = row_q - COL_W'(1);
				feed.meta.col      = col_q - COL_W'(1);
				feed.meta.run_last = !(row_end && (row_q != '0));
				src.use_rd         = 1'b1;
				src.top_en         = (row_q >= COL_W'(2));
				src.bot_pixel      = 1'b1;
			end
			ST_ROW_TAIL: begin
				// zero column closes the last-column window of the row above
				feed.valid         = 1'b1;
				feed.emit          = 1'b1;
				feed.meta.row      = tail_row_q;
				feed.meta.col      = last_col;
				feed.meta.run_last = !frame_end_q;
			end
			ST_FLUSH: begin
				// banks already rotated: upper holds row n-2, middle holds row n-1
				feed.valid         = 1'b1;
				feed.first         = (flush_col_q == '0);
				feed.emit          = (flush_col_q != '0);
				feed.meta.row      = last_row;
				feed.meta.col      = flush_col_q - COL_W'(1);
				src.use_rd         = 1'b1;
				src.top_en         = 1'b1;
				addr_a             = {up_bank, flush_col_q};
				addr_b             = {mid_bank, flush_col_q};
			end
			ST_FLUSH_TAIL: begin
				feed.valid           = 1'b1;
				feed.emit            = 1'b1;
				feed.meta.row        = last_row;
				feed.meta.col        = last_col;
				feed.meta.run_last   = 1'b1;
				feed.meta.frame_last = 1'b1;
			end
			default: begin
				feed = '0;
			end
		endcase
	end

	assign addr_w = {low_bank_q, col_q};

	// Row memory: one write port, two registered read ports held on stall.
	always_ff @(posedge clk) begin
		if (accept) begin
			row_mem[addr_w] <= s_axis_tdata;
		end
		if (adv) begin
			rd_a_s1  <= row_mem[addr_a];
			rd_b_s1  <= row_mem[addr_b];
			pixel_s1 <= s_axis_tdata;
			src_s1   <= src;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_s1 <= '0;
		end else if (adv) begin
			cmd_s1 <= feed;
		end
	end

	// Zero whatever the column does not take from memory or the pixel.
	always_comb begin
		col_new.top = (src_s1.use_rd && src_s1.top_en) ? rd_a_s1 : '0;
		col_new.mid = src_s1.use_rd ? rd_b_s1 : '0;
		col_new.bot = src_s1.bot_pixel ? pixel_s1 : '0;
	end

	// Sequencer, position counters and configuration.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_STREAM;
			cols_q      <= SIZE_RESET;
			rows_q      <= SIZE_RESET;
			row_q       <= '0;
			col_q       <= '0;
			flush_col_q <= '0;
			tail_row_q  <= '0;
			frame_end_q <= 1'b0;
			low_bank_q  <= '0;
		end else if (cfg_we) begin
			// any write restarts the frame
			unique case (cfg_index)
				REG_COLS: cols_q <= cfg_data;
				REG_ROWS: rows_q <= cfg_data;
				default:  cols_q <= cols_q;
			endcase
			row_q <= '0;
			col_q <= '0;
		end else if (adv) begin
			unique case (state_q)
				ST_STREAM: begin
					if (accept) begin
						if (row_end) begin
							col_q       <= '0;
							row_q       <= frame_end ? '0 : row_q + COL_W'(1);
							low_bank_q  <= (low_bank_q == 2'd2) ? 2'd0 : low_bank_q + 2'd1;
							tail_row_q  <= row_q - COL_W'(1);
							frame_end_q <= frame_end;
							// row 0 has no row above to finish
							if (row_q != '0) begin
								state_q <= ST_ROW_TAIL;
							end
						end else begin
							col_q <= col_q + COL_W'(1);
						end
					end
				end
				ST_ROW_TAIL: begin
					flush_col_q <= '0;
					state_q     <= frame_end_q ? ST_FLUSH : ST_STREAM;
				end
				ST_FLUSH: begin
					if (flush_col_q == last_col) begin
						state_q <= ST_FLUSH_TAIL;
					end else begin
						flush_col_q <= flush_col_q + COL_W'(1);
					end
				end
				ST_FLUSH_TAIL: begin
					state_q <= ST_STREAM;
				end
				default: begin
					state_q <= ST_STREAM;
				end
			endcase
		end
	end

	wna_calc u_calc (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.cmd_s1    (cmd_s1),
		.col_new   (col_new),
		.res_valid (res_valid),
		.res_avg   (res_avg),
		.res_meta  (res_meta)
	);

	// The calc output register is the result stream's register.
	assign m_axis_tvalid = res_valid;
	assign m_axis_tdata  = {res_meta.col, res_meta.row, res_avg};
	assign m_axis_tlast  = res_meta.run_last;
	assign m_axis_tuser  = res_meta.frame_last;

endmodule

FILE: sv/wna_chk.sv
// Port checker for the weighted neighbour average unit, bound to the top level.
// Depends on weighted_neighbour_average_3x3_unit_assert.svh.
`include "weighted_neighbour_average_3x3_unit_assert.svh"

module wna_chk (
	input logic clk,
	input logic arst_n,
	input logic s_axis_tvalid,
	input logic s_axis_tready,
	input logic m_axis_tvalid,
	input logic m_axis_tready,
	input logic m_axis_tlast,
	input logic m_axis_tuser
);

	// a pending result holds until its transaction completes
	`WNA_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid, "result dropped before transaction")

	// a stalled output blocks new input
	`WNA_ASSERT(a_in_stall, m_axis_tvalid && !m_axis_tready |-> !s_axis_tready, "input taken while output stalled")

	// the frame's final result also ends its run
	`WNA_ASSERT(a_frame_run, m_axis_tvalid && m_axis_tuser |-> m_axis_tlast, "frame end without run end")

	// reset empties the output register
	`WNA_ASSERT_ALWAYS(a_rst_idle, !arst_n |-> !m_axis_tvalid, "result valid during reset")

endmodule

bind weighted_neighbour_average_3x3_unit wna_chk u_wna_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tlast  (m_axis_tlast),
	.m_axis_tuser  (m_axis_tuser)
);
